>>> design/lgpg_pkg.sv
// ----------------------------------------------------------------------------
// lgpg_pkg: shared types and constants of the linear gradient pixel generator
// Widths of the pixel and configuration fields, register map codes, and the
// structs that carry configuration and divider results between the modules.
// ----------------------------------------------------------------------------
package lgpg_pkg;

    localparam int IDX_W    = 24;
    localparam int COLOR_W  = 24;
    localparam int DIM_W    = 13;
    localparam int COUNT_W  = 2 * DIM_W;
    localparam int NUMER_W  = 31;
    localparam int PCT_W    = 7;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 25600.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam int          PROD_W      = 15;
    localparam int          SCALED_W    = 28;

    typedef enum logic [1:0] {
        REG_COLOR_START  = 2'd0,
        REG_COLOR_END    = 2'd1,
        REG_FRAME_WIDTH  = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] color_start;
        logic [COLOR_W-1:0] color_end;
        logic [COUNT_W-1:0] pixel_count;
    } t_cfg;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic             oor;
    } t_div_beat;

endpackage

>>> design/lgpg_if.sv
// ----------------------------------------------------------------------------
// lgpg_if: valid/ready stream interfaces of the gradient generator
// One interface carries pixel indexes in, the other carries colored pixels out.
// ----------------------------------------------------------------------------
interface lgpg_pix_if;
    import lgpg_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] pixel_index;

    modport source (output valid, output pixel_index, input ready);
    modport sink   (input valid, input pixel_index, output ready);
endinterface

interface lgpg_res_if;
    import lgpg_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic               index_out_of_range;

    modport source (output valid, output pixel_color, output index_out_of_range, input ready);
    modport sink   (input valid, input pixel_color, input index_out_of_range, output ready);
endinterface

>>> design/linear_gradient_pixel_generator.sv
// ----------------------------------------------------------------------------
// linear_gradient_pixel_generator: linear gradient fill over a whole frame
// Maps a raster pixel index to its color between a start and an end color.
// ----------------------------------------------------------------------------
// The block takes one pixel index and returns one pixel color per clock while
// result beats are taken: eight stages form index*100 and divide it by the
// frame pixel count one quotient bit at a time, and three stages weight,
// rescale and sum the color channels. Every stage holds a valid
// bit, so input ready stays high while the pipeline has an empty slot even when
// the output beat is not being taken. Registers sit on APB at byte addresses
// 0 (start color), 4 (end color), 8 (width) and 12 (height); paddr bits 1:0 are
// ignored. A write takes effect for indexes accepted in the following cycle.
// An index at or beyond width times height returns color zero with the
// out-of-range flag set.
module linear_gradient_pixel_generator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lgpg_pix_if.sink                     i_pix,
    lgpg_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lgpg_pkg::APB_AW-1:0]  paddr,
    input  logic [lgpg_pkg::APB_DW-1:0]  pwdata,
    output logic [lgpg_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import lgpg_pkg::*;

    t_cfg      w_cfg;
    logic      w_div_valid;
    logic      w_div_ready;
    t_div_beat w_div_beat;

    lgpg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lgpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (w_cfg),
        .o_valid (w_div_valid),
        .i_ready (w_div_ready),
        .o_beat  (w_div_beat)
    );

    lgpg_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .o_ready (w_div_ready),
        .i_beat  (w_div_beat),
        .i_cfg   (w_cfg),
        .o_res   (o_res)
    );

endmodule

>>> design/lgpg_cfg.sv
// ----------------------------------------------------------------------------
// lgpg_cfg: APB configuration registers
// Holds the two gradient colors and the frame size, and keeps the frame pixel
// count in a register so the datapath never sees the multiplier.
// ----------------------------------------------------------------------------
module lgpg_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lgpg_pkg::APB_AW-1:0]  paddr,
    input  logic [lgpg_pkg::APB_DW-1:0]  pwdata,
    output logic [lgpg_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output lgpg_pkg::t_cfg               o_cfg
);
    import lgpg_pkg::*;

    logic [COLOR_W-1:0] r_color_start;
    logic [COLOR_W-1:0] r_color_end;
    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic [COUNT_W-1:0] r_pixel_count;
    logic               w_wr;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_start  <= '0;
            r_color_end    <= '0;
            r_frame_width  <= DIM_W'(1);
            r_frame_height <= DIM_W'(1);
            r_pixel_count  <= COUNT_W'(1);
        end else begin
            if (w_wr) begin
                unique case (w_idx)
                    REG_COLOR_START:  r_color_start  <= pwdata[COLOR_W-1:0];
                    REG_COLOR_END:    r_color_end    <= pwdata[COLOR_W-1:0];
                    REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                    REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            // Follows the dimensions in the next cycle; the divider reads it from stage 1
            // on, not in stage 0 where the index is taken.
            r_pixel_count <= {{DIM_W{1'b0}}, r_frame_width} * {{DIM_W{1'b0}}, r_frame_height};
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_COLOR_START:  prdata = APB_DW'(r_color_start);
            REG_COLOR_END:    prdata = APB_DW'(r_color_end);
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = '{color_start: r_color_start,
                     color_end:   r_color_end,
                     pixel_count: r_pixel_count};

`ifndef SYNTH
    a_width_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && (w_idx == REG_FRAME_WIDTH) |=> r_frame_width == $past(pwdata[DIM_W-1:0]))
        else $error("frame width register did not take the written value");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_pixel_count ==
            COUNT_W'($past(r_frame_width)) * COUNT_W'($past(r_frame_height)))
        else $error("pixel count does not match the frame dimensions");
`endif

endmodule

>>> design/lgpg_div.sv
// ----------------------------------------------------------------------------
// lgpg_div: pipelined percent divider
// Forms index*100 and divides it by the pixel count with a restoring divider,
// one quotient bit per stage, and flags indexes beyond the frame.
// ----------------------------------------------------------------------------
module lgpg_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lgpg_pix_if.sink              i_pix,
    input  lgpg_pkg::t_cfg        i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output lgpg_pkg::t_div_beat   o_beat
);
    import lgpg_pkg::*;

    // Stage 0 takes the index, stages 1 to PCT_W each settle one quotient bit.
    localparam int NSTG = PCT_W + 1;
    localparam int DIVW = COUNT_W + PCT_W;

    logic [NSTG-1:0]    r_valid;
    logic [NSTG-1:0]    w_adv;
    logic [IDX_W-1:0]   r_idx;
    logic [NUMER_W-1:0] r_rem [NSTG];
    logic [PCT_W-1:0]   r_quo [NSTG];
    logic               r_oor [1:NSTG-1];
    logic [NUMER_W-1:0] w_rem_n [1:NSTG-1];
    logic               w_ge [1:NSTG-1];
    logic [DIVW-1:0]    w_dvs [1:NSTG-1];
    logic               w_oor;

    always_comb begin
        w_adv[NSTG-1] = !r_valid[NSTG-1] || i_ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            w_adv[s] = !r_valid[s] || w_adv[s+1];
        end
    end

    assign i_pix.ready = w_adv[0];
    assign w_oor = {{(COUNT_W-IDX_W){1'b0}}, r_idx} >= i_cfg.pixel_count;

    always_comb begin
        for (int s = 1; s < NSTG; s++) begin
            w_dvs[s]   = DIVW'(i_cfg.pixel_count) << (NSTG - 1 - s);
            w_ge[s]    = DIVW'(r_rem[s-1]) >= w_dvs[s];
            w_rem_n[s] = w_ge[s] ? (r_rem[s-1] - w_dvs[s][NUMER_W-1:0]) : r_rem[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_adv[0]) begin
                r_valid[0] <= i_pix.valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (w_adv[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_idx    <= i_pix.pixel_index;
            // index * 100 as shifts: 64 + 32 + 4.
            r_rem[0] <= (NUMER_W'(i_pix.pixel_index) << 6) + (NUMER_W'(i_pix.pixel_index) << 5)
                      + (NUMER_W'(i_pix.pixel_index) << 2);
            r_quo[0] <= '0;
        end
        for (int s = 1; s < NSTG; s++) begin
            if (w_adv[s]) begin
                r_rem[s] <= w_rem_n[s];
                r_quo[s] <= {r_quo[s-1][PCT_W-2:0], w_ge[s]};
                r_oor[s] <= (s == 1) ? w_oor : r_oor[(s > 1) ? s - 1 : 1];
            end
        end
    end

    assign o_valid = r_valid[NSTG-1];
    assign o_beat  = '{pct: r_quo[NSTG-1], oor: r_oor[NSTG-1]};

`ifndef SYNTH
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_beat.oor |-> o_beat.pct < PCT_SCALE)
        else $error("percent out of range for an in-frame pixel");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> r_valid == '0)
        else $error("divider pipeline holds beats after reset");
`endif

endmodule

>>> design/lgpg_blend.sv
// ----------------------------------------------------------------------------
// lgpg_blend: per-channel color blend pipeline
// Weights start and end colors by the percent, divides each product by 100
// through a reciprocal multiply, and sums and packs the channels.
// ----------------------------------------------------------------------------
module lgpg_blend (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  lgpg_pkg::t_div_beat   i_beat,
    input  lgpg_pkg::t_cfg        i_cfg,
    lgpg_res_if.source            o_res
);
    import lgpg_pkg::*;

    localparam int NSTG = 3;

    logic [NSTG-1:0]     r_valid;
    logic [NSTG-1:0]     w_adv;
    logic [PCT_W-1:0]    w_inv;
    logic                r_oor [NSTG];
    logic [PROD_W-1:0]   r_ps [NUM_CHAN];
    logic [PROD_W-1:0]   r_pe [NUM_CHAN];
    logic [SCALED_W-1:0] r_qs [NUM_CHAN];
    logic [SCALED_W-1:0] r_qe [NUM_CHAN];
    logic [COLOR_W-1:0]  r_color;
    logic [COLOR_W-1:0]  n_color;

    always_comb begin
        w_adv[NSTG-1] = !r_valid[NSTG-1] || o_res.ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            w_adv[s] = !r_valid[s] || w_adv[s+1];
        end
    end

    assign o_ready = w_adv[0];
    assign w_inv   = PCT_SCALE - i_beat.pct;

    always_comb begin
        logic [CHAN_W:0] v_s;
        logic [CHAN_W:0] v_e;
        n_color = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            v_s = (CHAN_W+1)'(r_qs[c] >> RECIP_SHIFT);
            v_e = (CHAN_W+1)'(r_qe[c] >> RECIP_SHIFT);
            n_color[c*CHAN_W +: CHAN_W] = CHAN_W'(v_s + v_e);
        end
        if (r_oor[1]) begin
            n_color = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_adv[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (w_adv[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_oor[0] <= i_beat.oor;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_ps[c] <= PROD_W'(i_cfg.color_start[c*CHAN_W +: CHAN_W]) * PROD_W'(w_inv);
                r_pe[c] <= PROD_W'(i_cfg.color_end[c*CHAN_W +: CHAN_W]) * PROD_W'(i_beat.pct);
            end
        end
        if (w_adv[1]) begin
            r_oor[1] <= r_oor[0];
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_qs[c] <= SCALED_W'(r_ps[c]) * SCALED_W'(RECIP_100);
                r_qe[c] <= SCALED_W'(r_pe[c]) * SCALED_W'(RECIP_100);
            end
        end
        if (w_adv[2]) begin
            r_oor[2] <= r_oor[1];
            r_color  <= n_color;
        end
    end

    assign o_res.valid              = r_valid[NSTG-1];
    assign o_res.pixel_color        = r_color;
    assign o_res.index_out_of_range = r_oor[NSTG-1];

`ifndef SYNTH
    a_oor_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.index_out_of_range |-> o_res.pixel_color == '0)
        else $error("out-of-frame pixel carries a nonzero color");
`endif

endmodule

>>> tb/lgpg_gradient_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpg_gradient_checker: scoreboard for the linear gradient pixel generator
// Follows register writes on the APB port, predicts the color and range flag
// of every pixel index beat taken in, and compares each result beat in order.
// ----------------------------------------------------------------------------
module lgpg_gradient_checker
    import lgpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    lgpg_pix_if               i_pix,
    lgpg_res_if               i_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_checked,
    output int                o_out_of_range
);

    localparam longint unsigned PERCENT = 100;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               oor;
    } t_pixel_out;

    t_pixel_out         expected_pixels[$];
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;
    logic [DIM_W-1:0]   width_px;
    logic [DIM_W-1:0]   height_px;
    int                 mismatch_count = 0;
    int                 checked_count = 0;
    int                 oor_count = 0;

    assign o_mismatches   = mismatch_count;
    assign o_checked      = checked_count;
    assign o_out_of_range = oor_count;

    // Each channel is the start value weighted by (100 - p) plus the end value
    // weighted by p, both floored separately, with p the whole percent position.
    function automatic t_pixel_out gradient_color(input logic [IDX_W-1:0] idx);
        t_pixel_out      px;
        longint unsigned count;
        longint unsigned pct;
        longint unsigned s_ch;
        longint unsigned e_ch;
        px    = '0;
        count = 64'(width_px) * 64'(height_px);
        if (64'(idx) >= count) begin
            px.oor = 1'b1;
            return px;
        end
        pct = (64'(idx) * PERCENT) / count;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            s_ch = 64'(start_color[CHAN_W*ch +: CHAN_W]);
            e_ch = 64'(end_color[CHAN_W*ch +: CHAN_W]);
            px.color[CHAN_W*ch +: CHAN_W] =
                CHAN_W'((s_ch * (PERCENT - pct)) / PERCENT + (e_ch * pct) / PERCENT);
        end
        return px;
    endfunction

    task automatic report_mismatch(input string what, input t_pixel_out got,
                                   input t_pixel_out want);
        mismatch_count++;
        $display("%0t: %s: got color %06h flag %0b, expected color %06h flag %0b",
                 $time, what, got.color, got.oor, want.color, want.oor);
    endtask

    always @(posedge i_clk) begin : monitor
        t_pixel_out got;
        t_pixel_out want;
        if (!i_rst_n) begin
            start_color = '0;
            end_color   = '0;
            width_px    = DIM_W'(1);
            height_px   = DIM_W'(1);
            expected_pixels.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_COLOR_START:  start_color = pwdata[COLOR_W-1:0];
                    REG_COLOR_END:    end_color   = pwdata[COLOR_W-1:0];
                    REG_FRAME_WIDTH:  width_px    = pwdata[DIM_W-1:0];
                    REG_FRAME_HEIGHT: height_px   = pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                got.color = i_res.pixel_color;
                got.oor   = i_res.index_out_of_range;
                checked_count++;
                if (got.oor === 1'b1) begin
                    oor_count++;
                end
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result beat with no pixel outstanding", got, '0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.color !== want.color) begin
                        report_mismatch("pixel_color", got, want);
                    end
                    if (got.oor !== want.oor) begin
                        report_mismatch("index_out_of_range", got, want);
                    end
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                expected_pixels.push_back(gradient_color(i_pix.pixel_index));
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

>>> tb/tb_linear_gradient_pixel_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_gradient_pixel_generator: testbench of the gradient pixel generator
// Programs colors and frame sizes over APB, streams pixel indexes through the
// block under several idle and stall patterns, and lets the checker compare
// every result beat against its own prediction.
// ----------------------------------------------------------------------------
module tb_linear_gradient_pixel_generator;
    import lgpg_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 6;
    localparam int STALL_LIMIT      = 5000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_ITEMS       = 40;
    localparam int DRAIN_CYCLES     = 16;
    localparam int BLOCK_ITEMS      = 50;
    localparam int BLOCKS_PER_PHASE = 5;
    localparam int NUM_PHASES       = 4;
    localparam int TX_IDLE [NUM_PHASES]  = '{0, 50, 0, 34};
    localparam int RX_STALL [NUM_PHASES] = '{0, 0, 50, 34};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                tx_idle_pct;
    int                rx_stall_pct;
    bit                hold_req;
    logic [DIM_W-1:0]  cur_width;
    logic [DIM_W-1:0]  cur_height;
    int                pixels_sent;
    int                settings_used;
    int                mismatches;
    int                pending;
    int                checked;
    int                oor_seen;

    lgpg_pix_if pix_if ();
    lgpg_res_if res_if ();

    always #(CLK_HALF) i_clk = ~i_clk;

    linear_gradient_pixel_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lgpg_gradient_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (pix_if),
        .i_res          (res_if),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_out_of_range (oor_seen)
    );

    task automatic write_reg(input t_reg_idx r, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({r, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [APB_DW-1:0] start_v, input logic [APB_DW-1:0] end_v,
                                input logic [APB_DW-1:0] dim_w, input logic [APB_DW-1:0] dim_h);
        write_reg(REG_COLOR_START, start_v);
        write_reg(REG_COLOR_END, end_v);
        write_reg(REG_FRAME_WIDTH, dim_w);
        write_reg(REG_FRAME_HEIGHT, dim_h);
        cur_width  = dim_w[DIM_W-1:0];
        cur_height = dim_h[DIM_W-1:0];
        settings_used++;
    endtask

    // Returns at the edge that took the beat, without touching valid there.
    task automatic send_pixel(input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_index <= idx;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    // The checker's pending count is registered at each edge, hence the first wait.
    task automatic drain();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [APB_DW-1:0] random_dim();
        logic [APB_DW-1:0] dim;
        case ($urandom_range(19))
            0:          dim = 0;
            1:          dim = 1;
            2:          dim = 4096;
            3:          dim = 8191;
            4, 5, 6, 7: dim = $urandom_range(1, 4096);
            default:    dim = $urandom_range(1, 64);
        endcase
        // Junk above the field must be dropped by the register.
        if ($urandom_range(3) == 0) begin
            dim = dim | ($urandom << DIM_W);
        end
        return dim;
    endfunction

    // Mostly indexes inside the frame, with the frame edges and full-width noise.
    function automatic logic [IDX_W-1:0] random_index();
        longint unsigned count;
        count = 64'(cur_width) * 64'(cur_height);
        if (count == 0 || count > (64'd1 << IDX_W) || $urandom_range(9) == 0) begin
            return IDX_W'($urandom);
        end
        case ($urandom_range(19))
            0:       return '0;
            1:       return IDX_W'(count - 1);
            2:       return IDX_W'(count);
            default: return IDX_W'($urandom_range(0, 32'(count - 1)));
        endcase
    endfunction

    initial begin : result_sink
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("No beat moved for %0d cycles with %0d results outstanding.",
                 STALL_LIMIT, pending);
        $display("[linear_gradient_pixel_generator] ERROR");
        $finish;
    end

    initial begin : stimulus
        i_rst_n            = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.pixel_index = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        tx_idle_pct        = 0;
        rx_stall_pct       = 0;
        hold_req           = 1'b0;
        cur_width          = DIM_W'(1);
        cur_height         = DIM_W'(1);
        pixels_sent        = 0;
        settings_used      = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the frame is a single black pixel.
        send_pixel('0);
        send_pixel(IDX_W'(1));
        send_pixel('1);
        drain();

        // A 100-pixel frame makes the percent equal to the index.
        write_config(32'hFFFF_FFFF, 32'h0000_0000, 10, 10);
        send_pixel('0);
        send_pixel(IDX_W'(1));
        send_pixel(IDX_W'(50));
        send_pixel(IDX_W'(99));
        send_pixel(IDX_W'(100));
        send_pixel('1);
        drain();

        // Largest nominal frame: the last index lands on 99 percent.
        write_config(32'h00FF_00FF, 32'h0000_FF00, 4096, 4096);
        send_pixel('0);
        send_pixel(IDX_W'(167772));
        send_pixel('1);
        drain();

        // Width written as zero once its upper junk is masked: nothing is in range.
        write_config(32'h0012_3456, 32'h00AB_CDEF, 32'hFFFF_E000, 5);
        send_pixel('0);
        send_pixel(IDX_W'(3));
        drain();

        // Dimensions past 4096 are used as written.
        write_config(32'h0012_3456, 32'h00FF_FFFF, 8191, 8191);
        send_pixel('0);
        send_pixel(IDX_W'(24'h80_0000));
        send_pixel('1);
        drain();

        // White to white peaks the channel sum just below full scale.
        write_config(32'h00FF_FFFF, 32'h00FF_FFFF, 1, 100);
        send_pixel(IDX_W'(99));
        send_pixel(IDX_W'(100));
        drain();

        // Hold the result side off long enough for the input to back up.
        write_config($urandom, $urandom, random_dim(), random_dim());
        hold_req = 1'b1;
        for (int n = 0; n < HOLD_ITEMS; n++) begin
            send_pixel(random_index());
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            tx_idle_pct  = TX_IDLE[ph];
            rx_stall_pct = RX_STALL[ph];
            for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
                write_config($urandom, $urandom, random_dim(), random_dim());
                for (int n = 0; n < BLOCK_ITEMS; n++) begin
                    send_pixel(random_index());
                end
                drain();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d pixel indexes under %0d register settings; %0d results checked, %0d out of range.",
                 pixels_sent, settings_used, checked, oor_seen);
        $display("Ran idle-free, sender-idle, receiver-stall and mixed phases plus a %0d-cycle hold-off.",
                 LONG_HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("[linear_gradient_pixel_generator] OK");
        end else begin
            $display("[linear_gradient_pixel_generator] ERROR");
        end
        $finish;
    end

endmodule
